@@ rtl/core/pdn_pkg.sv @@
// ----------------------------------------------------------------------------
// pdn_pkg
// Types, constants and small lookup functions shared by the packed date to
// day number unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pdn_pkg;

    // field widths
    localparam int unsigned PACKED_W = 27;
    localparam int unsigned DAYNUM_W = 22;
    localparam int unsigned ERR_W    = 3;
    localparam int unsigned QUOT_W   = 14;   // packed / 10000, up to 13421
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 7;
    localparam int unsigned DAY_W    = 8;    // day field may reach 134
    localparam int unsigned CENT_W   = 7;    // year / 100, up to 99

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK           = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_POSITIVE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_YEAR         = 3'd2;
    localparam logic [ERR_W-1:0] ERR_MONTH        = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DAY          = 3'd4;

    // reciprocal constants: floor(x / d) == (x * MULT) >> SHIFT over the input range
    localparam int unsigned       DIV10K_SHIFT = 41;
    localparam logic [27:0]       DIV10K_MULT  = 28'd219902326;
    localparam int unsigned       DIV100_SHIFT = 21;
    localparam logic [14:0]       DIV100_MULT  = 15'd20972;

    localparam logic [13:0]       TEN_THOUSAND  = 14'd10000;
    localparam logic [6:0]        ONE_HUNDRED   = 7'd100;
    localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;

    // fields split out of one packed date
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        logic [CENT_W-1:0]    century;
    } pdn_fields_t;

    // days before the first of a month in a common year
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // month length, february resolved by the leap flag
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month)
            4'd2:                            n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:         n = 5'd30;
            default:                         n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdn_split.sv @@
// ----------------------------------------------------------------------------
// pdn_split
// Splits a registered ddmmyyyy value into day, month, year and century
// with reciprocal multiplies, three register stages, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdn_split
    import pdn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [PACKED_W-1:0] in_value,
    output pdn_fields_t              fields
);

    // stage 1: quotient by 10000
    logic                 s1_valid_reg;
    logic [PACKED_W-1:0]  s1_value_reg;
    logic [QUOT_W-1:0]    s1_quot_reg;
    logic [QUOT_W-1:0]    s1_quot_next;
    logic [54:0]          s1_prod;

    assign s1_prod      = 55'(in_value) * 55'(DIV10K_MULT);
    assign s1_quot_next = QUOT_W'(s1_prod >> DIV10K_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_value_reg <= in_value;
        s1_quot_reg  <= s1_quot_next;
    end

    // stage 2: year remainder and day quotient
    logic                 s2_valid_reg;
    logic                 s2_zero_reg;
    logic [QUOT_W-1:0]    s2_quot_reg;
    logic [YEAR_W-1:0]    s2_year_reg;
    logic [DAY_W-1:0]     s2_day_reg;
    logic [YEAR_W-1:0]    s2_year_next;
    logic [DAY_W-1:0]     s2_day_next;
    logic [PACKED_W-1:0]  s2_rem_wide;
    logic [28:0]          s2_prod;

    assign s2_rem_wide  = s1_value_reg - PACKED_W'(s1_quot_reg) * PACKED_W'(TEN_THOUSAND);
    assign s2_year_next = s2_rem_wide[YEAR_W-1:0];
    assign s2_prod      = 29'(s1_quot_reg) * 29'(DIV100_MULT);
    assign s2_day_next  = DAY_W'(s2_prod >> DIV100_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_zero_reg <= (s1_value_reg == '0);
        s2_quot_reg <= s1_quot_reg;
        s2_year_reg <= s2_year_next;
        s2_day_reg  <= s2_day_next;
    end

    // stage 3: month remainder and century of the year
    logic                 s3_valid_reg;
    logic                 s3_zero_reg;
    logic [DAY_W-1:0]     s3_day_reg;
    logic [MONTH_W-1:0]   s3_month_reg;
    logic [YEAR_W-1:0]    s3_year_reg;
    logic [CENT_W-1:0]    s3_century_reg;
    logic [QUOT_W-1:0]    s3_month_wide;
    logic [28:0]          s3_prod;

    assign s3_month_wide = s2_quot_reg - QUOT_W'(s2_day_reg) * QUOT_W'(ONE_HUNDRED);
    assign s3_prod       = 29'(s2_year_reg) * 29'(DIV100_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_zero_reg    <= s2_zero_reg;
        s3_day_reg     <= s2_day_reg;
        s3_month_reg   <= s3_month_wide[MONTH_W-1:0];
        s3_year_reg    <= s2_year_reg;
        s3_century_reg <= CENT_W'(s3_prod >> DIV100_SHIFT);
    end

    assign fields.valid   = s3_valid_reg;
    assign fields.zero    = s3_zero_reg;
    assign fields.day     = s3_day_reg;
    assign fields.month   = s3_month_reg;
    assign fields.year    = s3_year_reg;
    assign fields.century = s3_century_reg;

endmodule

`default_nettype wire

@@ rtl/core/packed_date_to_day_number_unit.sv @@
// ----------------------------------------------------------------------------
// packed_date_to_day_number_unit
// Converts a date packed as decimal ddmmyyyy into a Gregorian day number
// counted from 1.1.0001, with range checks and an error code.
// ----------------------------------------------------------------------------
// Usage:
//   - a date beat is taken at a rising edge with start high and busy low;
//     busy stays low, so a new date may be given in every cycle
//   - each date gives one result beat: done is high for exactly one cycle
//     with day_number, error_code and bad_value valid in that same cycle
//   - done follows the input register, three split stages, the leap and
//     year-days stage, and the result register that takes checks and sum
//   - throughput: one date per cycle, fully pipelined; the depth is set by
//     the chain of reciprocal multiplies that take the decimal fields apart
//   - checks run in order: value zero, year zero, month out of 1..12, day
//     out of the month; only the first failure is reported, a month or day with its field
//   - the receiver cannot stall; results are not held beyond their cycle
//   - reset clears all valid flags, so nothing is reported after reset
//     until a new date is taken
// ----------------------------------------------------------------------------
`default_nettype none

module packed_date_to_day_number_unit
    import pdn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire logic [PACKED_W-1:0] packed_date,
    output      logic                done,
    output      logic [DAYNUM_W-1:0] day_number,
    output      logic [ERR_W-1:0]    error_code,
    output      logic [PACKED_W-1:0] bad_value
);

    // never back-pressured
    assign busy = 1'b0;

    // input register
    logic                in_valid_reg;
    logic [PACKED_W-1:0] in_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_value_reg <= packed_date;
    end

    // field split
    pdn_fields_t split_fields;

    pdn_split u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_value (in_value_reg),
        .fields   (split_fields)
    );

    // stage 4: leap flag and days of all full years before this one
    logic [CENT_W-1:0]   yr_low;
    logic                yr_leap;
    logic [YEAR_W-1:0]   yr_prev;
    logic [CENT_W-1:0]   prev_cent;
    logic [DAYNUM_W-1:0] year_days_next;

    assign yr_low    = CENT_W'(split_fields.year - YEAR_W'(split_fields.century) *
                               YEAR_W'(ONE_HUNDRED));
    assign yr_leap   = (yr_low != '0) ? (split_fields.year[1:0] == 2'b00)
                                      : (split_fields.century[1:0] == 2'b00);
    assign yr_prev   = split_fields.year - YEAR_W'(1);
    // (year - 1) / 100 steps down only when the year is a whole century
    assign prev_cent = (yr_low != '0) ? split_fields.century
                                      : split_fields.century - CENT_W'(1);
    assign year_days_next = DAYNUM_W'(yr_prev) * DAYNUM_W'(DAYS_PER_YEAR)
                          + DAYNUM_W'(yr_prev >> 2)
                          - DAYNUM_W'(prev_cent)
                          + DAYNUM_W'(prev_cent >> 2);

    logic                s4_valid_reg;
    logic                s4_zero_reg;
    logic                s4_leap_reg;
    logic                s4_year_zero_reg;
    logic [DAY_W-1:0]    s4_day_reg;
    logic [MONTH_W-1:0]  s4_month_reg;
    logic [DAYNUM_W-1:0] s4_year_days_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= split_fields.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_zero_reg      <= split_fields.zero;
        s4_leap_reg      <= yr_leap;
        s4_year_zero_reg <= (split_fields.year == '0);
        s4_day_reg       <= split_fields.day;
        s4_month_reg     <= split_fields.month;
        s4_year_days_reg <= year_days_next;
    end

    // stage 5: checks in order and the final sum
    logic [3:0]          mon_idx;
    logic [4:0]          mon_len;
    logic [DAYNUM_W-1:0] count;
    logic [DAYNUM_W-1:0] day_number_next;
    logic [ERR_W-1:0]    error_code_next;
    logic [PACKED_W-1:0] bad_value_next;

    assign mon_idx = s4_month_reg[3:0];
    assign mon_len = month_len(mon_idx, s4_leap_reg);
    assign count   = s4_year_days_reg
                   + DAYNUM_W'(days_before(mon_idx))
                   + DAYNUM_W'((mon_idx > 4'd2) && s4_leap_reg)
                   + DAYNUM_W'(s4_day_reg);

    always_comb
    begin
        day_number_next = '0;
        error_code_next = ERR_OK;
        bad_value_next  = '0;
        if (s4_zero_reg)
        begin
            error_code_next = ERR_NOT_POSITIVE;
        end
        else if (s4_year_zero_reg)
        begin
            error_code_next = ERR_YEAR;
        end
        else if (s4_month_reg == '0 || s4_month_reg > MONTH_W'(12))
        begin
            error_code_next = ERR_MONTH;
            bad_value_next  = PACKED_W'(s4_month_reg);
        end
        else if (s4_day_reg == '0 || s4_day_reg > DAY_W'(mon_len))
        begin
            error_code_next = ERR_DAY;
            bad_value_next  = PACKED_W'(s4_day_reg);
        end
        else
        begin
            day_number_next = count;
        end
    end

    // result register
    logic                done_reg;
    logic [DAYNUM_W-1:0] day_number_reg;
    logic [ERR_W-1:0]    error_code_reg;
    logic [PACKED_W-1:0] bad_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        day_number_reg <= day_number_next;
        error_code_reg <= error_code_next;
        bad_value_reg  <= bad_value_next;
    end

    assign done       = done_reg;
    assign day_number = day_number_reg;
    assign error_code = error_code_reg;
    assign bad_value  = bad_value_reg;

endmodule

`default_nettype wire
